// File: rtl/tcw_pkg.sv
package tcw_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] BLANK_COLOR  = 8'h0f;
  localparam logic [7:0] COLOR_RESET  = 8'h0f;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int POS_W      = 11;
  localparam int IDX_W      = 11;

  typedef struct packed {
    logic [7:0] color;
    logic [7:0] chr;
  } cell_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL,
    ST_RESULT
  } state_t;

endpackage

// File: rtl/tcw_mem.sv
module tcw_mem #(
  parameter int DEPTH = 2000
) (
  input  logic                       clk,
  input  tcw_pkg::mem_ctl_t          ctl,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  tcw_pkg::cell_t             wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output tcw_pkg::cell_t             rdata
);
  import tcw_pkg::*;

  cell_t mem_r [DEPTH];
  cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/tcw_ctrl.sv
module tcw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wen,
  input  logic [7:0]                           cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tcw_pkg::IN_DATA_W-1:0]        in_tdata,
  input  logic [0:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tcw_pkg::OUT_DATA_W-1:0]       out_tdata,
  output tcw_pkg::mem_ctl_t                    mem_ctl,
  output logic [$clog2(COLUMNS*ROWS)-1:0]      mem_waddr,
  output tcw_pkg::cell_t                       mem_wdata,
  output logic [$clog2(COLUMNS*ROWS)-1:0]      mem_raddr,
  input  tcw_pkg::cell_t                       mem_rdata
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int PW    = (AW > POS_W) ? AW : POS_W;

  localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_START = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] LAST_DST   = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] COL_STEP   = AW'(COLUMNS);

  state_t           state_r, state_nxt;
  logic [7:0]       color_r;
  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    pend_addr_r, pend_addr_nxt;
  logic [7:0]       res_char_r, res_char_nxt;
  logic [7:0]       res_color_r, res_color_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic             in_req;
  logic [7:0]       in_char;
  logic [IDX_W-1:0] in_idx;
  logic             accept;
  logic             idx_ok;
  logic             out_free;
  logic [PW-1:0]    pos_ext;

  assign in_req   = in_tuser[0];
  assign in_char  = in_tdata[7:0];
  assign in_idx   = in_tdata[18:8];
  assign accept   = in_tvalid && in_tready;
  assign idx_ok   = ({21'd0, in_idx} < 32'(CELLS));
  assign out_free = !out_valid_r || out_tready;
  assign pos_ext  = PW'(pos_r);

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    res_char_nxt  = res_char_r;
    res_color_nxt = res_color_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          res_char_nxt  = 8'd0;
          res_color_nxt = 8'd0;
          state_nxt     = ST_RESULT;
          if (in_req == REQ_READ) begin
            if (idx_ok) begin
              state_nxt = ST_READ;
            end
          end else if (in_char == NEWLINE_CODE || col_r == LAST_COL) begin
            // line end: newline or wrap off the last column
            col_nxt = '0;
            if (row_r == LAST_ROW) begin
              pos_nxt   = LAST_START;
              cnt_nxt   = '0;
              state_nxt = ST_COPY;
            end else begin
              row_nxt = row_r + 1'b1;
              pos_nxt = pos_r - AW'(col_r) + COL_STEP;
            end
          end else begin
            col_nxt = col_r + 1'b1;
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      ST_READ: begin
        res_char_nxt  = mem_rdata.chr;
        res_color_nxt = mem_rdata.color;
        state_nxt     = ST_RESULT;
      end
      ST_COPY: begin
        // read one row ahead, write the cell back in the next cycle
        pend_nxt      = 1'b1;
        pend_addr_nxt = cnt_r;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == LAST_DST) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (!pend_r) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == LAST_CELL) begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, res_color_r, res_char_r, pos_ext[POS_W-1:0]};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // handshake and memory controls
  always_comb begin
    in_tready  = 1'b0;
    mem_ctl    = '0;
    mem_waddr  = cnt_r;
    mem_raddr  = AW'(in_idx);
    mem_wdata  = '{color: BLANK_COLOR, chr: BLANK_CHAR};
    case (state_r)
      ST_CLEAR: begin
        mem_ctl.we = 1'b1;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_req == REQ_READ) begin
            mem_ctl.re = idx_ok;
          end else if (in_char != NEWLINE_CODE) begin
            mem_ctl.we = 1'b1;
            mem_waddr  = pos_r;
            mem_wdata  = '{color: color_r, chr: in_char};
          end
        end
      end
      ST_COPY: begin
        mem_ctl.re = 1'b1;
        mem_raddr  = cnt_r + COL_STEP;
        mem_ctl.we = pend_r;
        mem_waddr  = pend_addr_r;
        mem_wdata  = mem_rdata;
      end
      ST_FILL: begin
        mem_ctl.we = 1'b1;
        if (pend_r) begin
          mem_waddr = pend_addr_r;
          mem_wdata = mem_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      color_r     <= COLOR_RESET;
      col_r       <= '0;
      row_r       <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        color_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    res_char_r  <= res_char_nxt;
    res_color_r <= res_color_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) < CELLS)
    else $error("cursor position beyond screen");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < COLUMNS && 32'(row_r) < ROWS)
    else $error("cursor row or column out of range");

  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.we |-> 32'(mem_waddr) < CELLS)
    else $error("screen write outside store");

  a_put_writes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req == REQ_PUT && in_char != NEWLINE_CODE |-> mem_ctl.we)
    else $error("printed character not written");

  a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COPY && pend_r |-> pend_addr_r + COL_STEP > cnt_r)
    else $error("scroll copy overtook its source");
`endif

endmodule

// File: rtl/text_console_writer_core.sv
// Text console writer: a screen store of ROWS x COLUMNS cells (character and
// attribute byte) with a cursor. Every request beat gives one result beat with
// the linear cursor position; reads within the screen also return the addressed
// cell, other reads return zero. After reset the store is blanked by a clearing
// pass over every cell during which no request is taken. An ordinary put goes from
// idle to the result state, which loads its result beat; a read inside the screen
// passes through the read state first, where the registered read data of the store
// is taken. A held result beat stalls the next one until out_tready. A put that
// scrolls also passes through the copy and fill states: the store has one write port, so
// the shift-up copy and the blank fill of the bottom row go one cell a cycle.
// text_color may only be written while no request is in flight.
module text_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wen,
  input  logic [7:0]                      cfg_wdata,  // text_color
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tcw_pkg::IN_DATA_W-1:0]   in_tdata,   // char_code, cell_index
  input  logic [0:0]                      in_tuser,   // req_type
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tcw_pkg::OUT_DATA_W-1:0]  out_tdata   // cursor_pos, read_char, read_color
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  cell_t         mem_wdata;
  cell_t         mem_rdata;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mem_ctl    (mem_ctl),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  tcw_mem #(
    .DEPTH (CELLS)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int IDLE_PCT = 28;
  // clearing pass or a scroll copy accepts nothing until it is through every cell
  localparam int STALL_LIMIT = 8 * (CELLS + 1);

  typedef struct packed {
    logic [POS_W-1:0] cursor_pos;
    logic [7:0]       read_char;
    logic [7:0]       read_colour;
  } screen_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wen = 1'b0;
  logic [7:0]            cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // char_code, cell_index
  logic [0:0]            in_tuser = '0;   // req_type
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // cursor_pos, read_char, read_color

  // shadow copy of the screen, cursor and attribute register
  logic [7:0]     shadow_char [CELLS];
  logic [7:0]     shadow_colour [CELLS];
  int             cur_row;
  int             cur_col;
  logic [7:0]     pen_colour;
  screen_result_t expected_results[$];
  int             error_count = 0;
  int             stall_cycles = 0;
  bit             steady = 1'b0;

  always #10 clk = ~clk;

  text_console_writer_core #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic screen_result_t advance_console(logic req, logic [7:0] code,
                                                     logic [IDX_W-1:0] idx);
    screen_result_t r;
    int at;
    r.read_char = '0;
    r.read_colour = '0;
    if (req == REQ_PUT) begin
      if (code == NEWLINE_CODE) begin
        cur_row++;
        cur_col = 0;
      end else begin
        at = cur_row * COLUMNS + cur_col;
        if (at < CELLS) begin
          shadow_char[at] = code;
          shadow_colour[at] = pen_colour;
        end
        cur_col++;
        if (cur_col >= COLUMNS) begin
          cur_row++;
          cur_col = 0;
        end
      end
      if (cur_row >= ROWS) begin
        for (int i = 0; i < CELLS - COLUMNS; i++) begin
          shadow_char[i] = shadow_char[i + COLUMNS];
          shadow_colour[i] = shadow_colour[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
          shadow_char[i] = BLANK_CHAR;
          shadow_colour[i] = BLANK_COLOR;
        end
        cur_row = ROWS - 1;
        cur_col = 0;
      end
    end else if (idx < CELLS) begin
      r.read_char = shadow_char[idx];
      r.read_colour = shadow_colour[idx];
    end
    r.cursor_pos = POS_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  // valid is left high after the beat so back-to-back requests need no second assignment
  task automatic push_request(input logic req, input logic [7:0] code,
                              input logic [IDX_W-1:0] idx);
    bit waited;
    waited = 1'b0;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      if (!waited) in_tvalid <= 1'b0;
      waited = 1'b1;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {{(IN_DATA_W - IDX_W - 8){1'b0}}, idx, code};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(advance_console(req, code, idx));
  endtask

  task automatic set_text_colour(input logic [7:0] colour);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= colour;
    @(posedge clk);
    cfg_wen <= 1'b0;
    pen_colour = colour;
  endtask

  task automatic check_blank_screen();
    push_request(REQ_READ, 8'hff, IDX_W'(0));
    push_request(REQ_READ, 8'h00, IDX_W'(CELLS - 1));
    // past the end of the screen reads as zero
    push_request(REQ_READ, 8'h0a, IDX_W'(CELLS));
    push_request(REQ_READ, 8'hff, '1);
  endtask

  task automatic check_put_and_newline();
    push_request(REQ_PUT, 8'h00, '0);
    push_request(REQ_PUT, 8'hff, '1);
    push_request(REQ_PUT, 8'h41, '1);
    push_request(REQ_PUT, NEWLINE_CODE, IDX_W'(5));
    // newline at column 0
    push_request(REQ_PUT, NEWLINE_CODE, '0);
    push_request(REQ_READ, 8'hff, IDX_W'(0));
    push_request(REQ_READ, 8'h00, IDX_W'(1));
    push_request(REQ_READ, 8'h00, IDX_W'(2));
  endtask

  task automatic check_colour_register();
    int at;
    at = cur_row * COLUMNS + cur_col;
    set_text_colour(8'hff);
    push_request(REQ_PUT, 8'h55, '0);
    set_text_colour(8'h00);
    push_request(REQ_PUT, 8'haa, '0);
    push_request(REQ_READ, 8'h00, IDX_W'(at));
    push_request(REQ_READ, 8'h00, IDX_W'(at + 1));
  endtask

  task automatic check_scroll();
    while (cur_row < ROWS - 1) push_request(REQ_PUT, NEWLINE_CODE, '0);
    push_request(REQ_PUT, 8'h7e, '0);
    // newline on the bottom row shifts the whole screen up
    push_request(REQ_PUT, NEWLINE_CODE, '0);
    push_request(REQ_READ, 8'h00, IDX_W'(0));
    push_request(REQ_READ, 8'h00, IDX_W'(COLUMNS + 1));
    push_request(REQ_READ, 8'h00, IDX_W'(CELLS - 2 * COLUMNS));
    push_request(REQ_READ, 8'h00, IDX_W'(CELLS - COLUMNS));
  endtask

  // lines of random text, mostly short, some long enough to wrap; reads mixed in
  task automatic check_random_text(input int count);
    int line_left;
    int pick;
    logic [IDX_W-1:0] idx;
    line_left = 0;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: idx = IDX_W'($urandom_range(CELLS - 3 * COLUMNS, CELLS - 1));
          4, 5, 6, 7: idx = IDX_W'($urandom_range(0, CELLS - 1));
          8:          idx = IDX_W'($urandom_range(CELLS, 2 ** IDX_W - 1));
          default:    idx = ($urandom_range(0, 1) == 0) ? '0 : '1;
        endcase
        push_request(REQ_READ, 8'($urandom), idx);
      end else if (line_left == 0) begin
        push_request(REQ_PUT, NEWLINE_CODE, IDX_W'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 70) line_left = $urandom_range(0, 4);
        else if (pick < 85) line_left = $urandom_range(5, 20);
        else line_left = $urandom_range(COLUMNS - 4, COLUMNS + 4);
      end else begin
        push_request(REQ_PUT, 8'($urandom), IDX_W'($urandom));
        line_left--;
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    screen_result_t want;
    screen_result_t got;
    if (out_tvalid && out_tready) begin
      got.cursor_pos = out_tdata[POS_W-1:0];
      got.read_char = out_tdata[POS_W+7:POS_W];
      got.read_colour = out_tdata[POS_W+15:POS_W+8];
      if (expected_results.size() == 0) begin
        $error("result beat with no request outstanding, cursor_pos %0d", got.cursor_pos);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.cursor_pos !== want.cursor_pos) begin
          $error("cursor_pos: expected %0d, got %0d", want.cursor_pos, got.cursor_pos);
          error_count++;
        end
        if (got.read_char !== want.read_char) begin
          $error("read_char: expected 0x%02h, got 0x%02h", want.read_char, got.read_char);
          error_count++;
        end
        if (got.read_colour !== want.read_colour) begin
          $error("read_color: expected 0x%02h, got 0x%02h", want.read_colour, got.read_colour);
          error_count++;
        end
      end
    end
    out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("text_console_writer_core verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      shadow_char[i] = BLANK_CHAR;
      shadow_colour[i] = BLANK_COLOR;
    end
    cur_row = 0;
    cur_col = 0;
    pen_colour = COLOR_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    check_blank_screen();
    check_put_and_newline();
    check_colour_register();
    check_scroll();

    set_text_colour(8'h00);
    check_random_text(150);
    set_text_colour(8'($urandom));
    steady = 1'b1;
    check_random_text(150);
    steady = 1'b0;
    set_text_colour(8'hff);
    check_random_text(160);

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("text_console_writer_core verification clean");
    end else begin
      $display("text_console_writer_core verification failed");
    end
    $finish;
  end

endmodule
